### rtl/assert_macros.svh
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Implication checked in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/pr3d_pkg.sv
// Types, constants and helpers of the road segment projector.
package pr3d_pkg;

    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 768;
    localparam int SEGMENT_SPAN  = 200;

    // Binary gcd, elaboration only.
    function automatic longint gcd(input longint a, input longint b);
        longint x;
        longint y;
        longint t;
        int     sh;
        x  = a;
        y  = b;
        sh = 0;
        while (((x | y) & 64'sd1) == 0) begin
            x  = x >>> 1;
            y  = y >>> 1;
            sh = sh + 1;
        end
        while ((x & 64'sd1) == 0) begin
            x = x >>> 1;
        end
        while (y != 0) begin
            while ((y & 64'sd1) == 0) begin
                y = y >>> 1;
            end
            if (x > y) begin
                t = x;
                x = y;
                y = t;
            end
            y = y - x;
        end
        return x <<< sh;
    endfunction

    // x = SW/2 + floor(SW*84*rel / (819200*span*k))
    localparam longint X_NUM = longint'(SCREEN_WIDTH) * 84;
    localparam longint X_DEN = longint'(SEGMENT_SPAN) * 819200;
    localparam longint X_G   = gcd(X_NUM, X_DEN);
    localparam longint A_X   = X_NUM / X_G;
    localparam longint B_X   = X_DEN / X_G;

    // y = SH/2 + floor(-SH*84*dh / (200*span*k))
    localparam longint Y_NUM = longint'(SCREEN_HEIGHT) * 84;
    localparam longint Y_DEN = longint'(SEGMENT_SPAN) * 200;
    localparam longint Y_G   = gcd(Y_NUM, Y_DEN);
    localparam longint A_Y   = Y_NUM / Y_G;
    localparam longint B_Y   = Y_DEN / Y_G;

    // hw = floor(840*SW / (span*k))
    localparam longint W_NUM = longint'(SCREEN_WIDTH) * 840;
    localparam longint W_DEN = longint'(SEGMENT_SPAN);
    localparam longint W_G   = gcd(W_NUM, W_DEN);
    localparam longint A_W   = W_NUM / W_G;
    localparam longint B_W   = W_DEN / W_G;

    localparam int DEPTH_W   = 12;
    localparam int QUOT_BITS = 17;
    localparam int QUOT_W    = QUOT_BITS + 1;
    localparam int SUM_W     = QUOT_W + 1;

    localparam int NX_W  = $clog2(A_X + 1) + 32;
    localparam int NY_W  = $clog2(A_Y + 1) + 17;
    localparam int NW_W  = $clog2(A_W + 1);
    localparam int BX_W  = $clog2(B_X + 1);
    localparam int BY_W  = $clog2(B_Y + 1);
    localparam int BW_W  = $clog2(B_W + 1);
    localparam int BM_W  = (BX_W > BY_W) ? ((BX_W > BW_W) ? BX_W : BW_W)
                                         : ((BY_W > BW_W) ? BY_W : BW_W);
    localparam int DEN_W = BM_W + DEPTH_W;
    localparam int NM_W  = (NX_W > NY_W) ? ((NX_W > NW_W) ? NX_W : NW_W)
                                         : ((NY_W > NW_W) ? NY_W : NW_W);
    localparam int MAG_W = (NM_W > DEN_W + QUOT_BITS) ? NM_W : DEN_W + QUOT_BITS;
    localparam int NUM_W = MAG_W + 1;

    localparam logic signed [SUM_W-1:0] X_BASE = SUM_W'(SCREEN_WIDTH / 2);
    localparam logic signed [SUM_W-1:0] Y_BASE = SUM_W'(SCREEN_HEIGHT / 2);
    localparam logic signed [SUM_W-1:0] W_BASE = '0;
    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_W'(32768);

    // floor(v/5) = (v*RECIP5) >> 20 for v < 2^18; floor(v/3) = (v*RECIP3) >> 13 for v < 2^13
    localparam logic [17:0] RECIP5 = 18'd209716;
    localparam logic [11:0] RECIP3 = 12'd2731;

    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_CAMERA_LATERAL = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CAMERA_HEIGHT  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_SEGMENT  = 2'd2;

    localparam logic signed [15:0] CAMERA_HEIGHT_RST = 16'sd1500;

    typedef struct packed {
        logic [11:0]        segment_number;
        logic signed [15:0] segment_height;
        logic signed [15:0] segment_curve;
    } t_item;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] bottom_y;
        logic signed [15:0] top_y;
        logic signed [15:0] bottom_x;
        logic signed [15:0] top_x;
        logic [14:0]        bottom_half_width;
        logic [14:0]        top_half_width;
        logic [14:0]        bottom_rumble_half_width;
        logic [14:0]        top_rumble_half_width;
        logic               color_band;
        logic signed [15:0] clip_row;
    } t_result;

    typedef struct packed {
        logic [REG_IDX_W-1:0] reg_index;
        logic [15:0]          wdata;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] camera_lateral;
        logic signed [15:0] camera_height;
        logic [11:0]        start_segment;
    } t_cam;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

### rtl/pr3d_stream_if.sv
// Valid/ready channel carrying one payload struct.
interface pr3d_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/pseudo3d_road_segment_projector_top.sv
// Top level of the pseudo-3D road segment projector.
//
// Channels: i_item takes one road segment per transfer (number, height, curve),
// near to far within a frame; o_result gives one quad per segment. i_cfg writes
// camera_lateral (0), camera_height (1) and start_segment (2); other indexes are
// ignored. i_cfg is always ready; write it only while the block is idle.
// Timing: a segment at nonzero depth runs three divisions (column, row, half
// width) through one shared divider at one quotient bit per cycle; a division
// whose quotient overflows saturates without iterating. Its result enters the
// output register once all three are done, and i_item is ready again in the
// cycle the result becomes valid. The start segment skips the divider.
// i_item is ready only while the sequencer is idle. The result sits in an output
// register; while the receiver stalls the next segment is still taken and
// computed, and waits in its final step until the register is free.
// Reset clears the frame state: offset and slope zero, horizon at the screen
// height, previous column at mid screen, previous row and half width saturated,
// and the camera registers at 0, 1500 and 0.
`include "assert_macros.svh"

module pseudo3d_road_segment_projector_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pr3d_stream_if.sink    i_item,
    pr3d_stream_if.source  o_result,
    pr3d_stream_if.sink    i_cfg
);

    logic signed [15:0]   r_cam_lateral;
    logic signed [15:0]   r_cam_height;
    logic [11:0]          r_start_segment;
    pr3d_pkg::t_cam       w_cam;
    pr3d_pkg::t_div_req   w_div_req;
    pr3d_pkg::t_div_rsp   w_div_rsp;
    logic                 w_item_xfer;
    logic                 w_top_above_clip;
    logic                 w_rumble_covers;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_lateral   <= '0;
            r_cam_height    <= pr3d_pkg::CAMERA_HEIGHT_RST;
            r_start_segment <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.reg_index)
                pr3d_pkg::REG_CAMERA_LATERAL: r_cam_lateral   <= i_cfg.data.wdata;
                pr3d_pkg::REG_CAMERA_HEIGHT:  r_cam_height    <= i_cfg.data.wdata;
                pr3d_pkg::REG_START_SEGMENT:  r_start_segment <= i_cfg.data.wdata[11:0];
                default: ;
            endcase
        end
    end

    assign w_cam.camera_lateral = r_cam_lateral;
    assign w_cam.camera_height  = r_cam_height;
    assign w_cam.start_segment  = r_start_segment;

    pr3d_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cam     (w_cam),
        .i_item    (i_item),
        .o_result  (o_result),
        .o_div_req (w_div_req),
        .i_div_rsp (w_div_rsp)
    );

    pr3d_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_item_xfer      = i_item.valid && i_item.ready;
    assign w_top_above_clip = !o_result.data.visible
                              || (o_result.data.top_y < o_result.data.clip_row);
    assign w_rumble_covers  =
        (o_result.data.top_rumble_half_width >= o_result.data.top_half_width)
        && (o_result.data.bottom_rumble_half_width >= o_result.data.bottom_half_width);

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_item_xfer, !i_item.ready)
    `ASSERT_IMPLIES(a_visible_above_clip, i_clk, i_rst_n, o_result.valid, w_top_above_clip)
    `ASSERT_IMPLIES(a_rumble_covers_road, i_clk, i_rst_n, o_result.valid, w_rumble_covers)

endmodule

### rtl/pr3d_divider.sv
// Iterative signed floor divider, one quotient bit per cycle, saturating quotient.
module pr3d_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pr3d_pkg::t_div_req  i_req,
    output pr3d_pkg::t_div_rsp  o_rsp
);

    localparam int CNT_W = $clog2(pr3d_pkg::QUOT_BITS + 1);
    localparam int MW    = pr3d_pkg::MAG_W;
    localparam int QB    = pr3d_pkg::QUOT_BITS;
    localparam int QW    = pr3d_pkg::QUOT_W;
    localparam int NW    = pr3d_pkg::NUM_W;

    localparam logic [1:0] DV_IDLE  = 2'd0;
    localparam logic [1:0] DV_CHECK = 2'd1;
    localparam logic [1:0] DV_ITER  = 2'd2;
    localparam logic [1:0] DV_FIN   = 2'd3;

    localparam logic signed [QW-1:0] QUOT_MAX = {1'b0, {QB{1'b1}}};
    localparam logic signed [QW-1:0] QUOT_MIN = {1'b1, {QB{1'b0}}};

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic             r_neg;
    logic             r_ovf;
    logic [MW-1:0]    r_rem;
    logic [MW-1:0]    r_ds;
    logic [QB-1:0]    r_q;
    logic [CNT_W-1:0] r_cnt;

    logic [NW-1:0]    w_abs;
    logic             w_ge;
    logic [MW-1:0]    w_diff;

    assign w_abs  = i_req.num[NW-1] ? NW'(-i_req.num) : i_req.num;
    assign w_ge   = (r_rem >= r_ds);
    assign w_diff = r_rem - r_ds;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DV_IDLE:  if (i_req.start) n_state = DV_CHECK;
            DV_CHECK: n_state = w_ge ? DV_FIN : DV_ITER;
            DV_ITER:  if (r_cnt == CNT_W'(1)) n_state = DV_FIN;
            DV_FIN:   n_state = DV_IDLE;
            default:  n_state = DV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DV_IDLE: begin
                if (i_req.start) begin
                    r_neg <= i_req.num[NW-1];
                    r_rem <= w_abs[MW-1:0];
                    r_ds  <= MW'(i_req.den) << QB;
                end
            end
            DV_CHECK: begin
                r_ovf <= w_ge;
                r_ds  <= r_ds >> 1;
                r_cnt <= CNT_W'(QB);
            end
            DV_ITER: begin
                if (w_ge) begin
                    r_rem <= w_diff;
                end
                r_q   <= {r_q[QB-2:0], w_ge};
                r_ds  <= r_ds >> 1;
                r_cnt <= r_cnt - CNT_W'(1);
            end
            default: ;
        endcase
    end

    always_comb begin
        o_rsp.done = (r_state == DV_FIN);
        if (r_ovf) begin
            o_rsp.quot = r_neg ? QUOT_MIN : QUOT_MAX;
        end else if (r_neg) begin
            // -q - (remainder != 0)
            o_rsp.quot = ~{1'b0, r_q} + QW'(r_rem == '0);
        end else begin
            o_rsp.quot = {1'b0, r_q};
        end
    end

endmodule

### rtl/pr3d_engine.sv
// Sequencer, frame state and result register of the road segment projector.
module pr3d_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pr3d_pkg::t_cam      i_cam,
    pr3d_stream_if.sink         i_item,
    pr3d_stream_if.source       o_result,
    output pr3d_pkg::t_div_req  o_div_req,
    input  pr3d_pkg::t_div_rsp  i_div_rsp
);

    localparam int NW = pr3d_pkg::NUM_W;
    localparam int DW = pr3d_pkg::DEN_W;
    localparam int SW = pr3d_pkg::SUM_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_PREP   = 3'd2;
    localparam logic [2:0] ST_LAUNCH = 3'd3;
    localparam logic [2:0] ST_WAIT   = 3'd4;
    localparam logic [2:0] ST_FINAL  = 3'd5;

    localparam logic [1:0] JOB_X = 2'd0;
    localparam logic [1:0] JOB_Y = 2'd1;
    localparam logic [1:0] JOB_W = 2'd2;

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic [1:0]               r_job;
    logic [11:0]              r_num_seg;
    logic signed [15:0]       r_height;
    logic signed [15:0]       r_curve;
    logic [11:0]              r_depth;
    logic signed [31:0]       r_offset;
    logic signed [31:0]       r_slope;
    logic signed [32:0]       r_rel;
    logic signed [16:0]       r_dh;
    logic                     r_band;
    logic signed [NW-1:0]     r_num;
    logic [DW-1:0]            r_den;
    logic signed [15:0]       r_x;
    logic signed [15:0]       r_y;
    logic [14:0]              r_hw;
    logic signed [15:0]       r_horizon;
    logic signed [15:0]       r_prev_x;
    logic signed [15:0]       r_prev_y;
    logic [14:0]              r_prev_hw;
    logic [14:0]              r_prev_rumble;
    pr3d_pkg::t_result        r_out;
    logic                     r_out_valid;

    logic                     w_start;
    logic signed [31:0]       w_off_base;
    logic signed [31:0]       w_slope_base;
    logic signed [31:0]       w_off_next;
    logic signed [31:0]       w_slope_next;
    logic [23:0]              w_band_prod;
    logic signed [63:0]       w_num_prod;
    logic signed [63:0]       w_den_prod;
    logic signed [SW-1:0]     w_base;
    logic signed [SW-1:0]     w_sum;
    logic signed [15:0]       w_sat16;
    logic [14:0]              w_satw;
    logic [17:0]              w_hw6;
    logic [35:0]              w_rprod;
    logic [14:0]              w_rumble;
    logic                     w_vis;
    logic                     w_out_free;

    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return s[31:0];
    endfunction

    assign w_start      = (r_depth == '0);
    assign w_off_base   = w_start ? '0 : r_offset;
    assign w_slope_base = w_start ? '0 : r_slope;
    assign w_off_next   = sat_add32(w_off_base, w_slope_base);
    assign w_slope_next = sat_add32(w_slope_base, 32'(r_curve));
    assign w_band_prod  = 24'(r_num_seg) * 24'(pr3d_pkg::RECIP3);

    always_comb begin
        case (r_job)
            JOB_X: begin
                w_num_prod = pr3d_pkg::A_X * longint'(r_rel);
                w_den_prod = pr3d_pkg::B_X * longint'(r_depth);
                w_base     = pr3d_pkg::X_BASE;
            end
            JOB_Y: begin
                w_num_prod = -(pr3d_pkg::A_Y * longint'(r_dh));
                w_den_prod = pr3d_pkg::B_Y * longint'(r_depth);
                w_base     = pr3d_pkg::Y_BASE;
            end
            JOB_W: begin
                w_num_prod = pr3d_pkg::A_W;
                w_den_prod = pr3d_pkg::B_W * longint'(r_depth);
                w_base     = pr3d_pkg::W_BASE;
            end
            default: begin
                w_num_prod = '0;
                w_den_prod = '0;
                w_base     = '0;
            end
        endcase
    end

    assign w_sum = {i_div_rsp.quot[pr3d_pkg::QUOT_W-1], i_div_rsp.quot} + w_base;

    always_comb begin
        if (w_sum > pr3d_pkg::SUM_HI) begin
            w_sat16 = 16'sh7fff;
            w_satw  = 15'h7fff;
        end else if (w_sum < pr3d_pkg::SUM_LO) begin
            w_sat16 = 16'sh8000;
            w_satw  = '0;
        end else begin
            w_sat16 = w_sum[15:0];
            w_satw  = w_sum[SW-1] ? '0 : w_sum[14:0];
        end
    end

    assign w_hw6    = {1'b0, r_hw, 2'b00} + {2'b00, r_hw, 1'b0};
    assign w_rprod  = 36'(w_hw6) * 36'(pr3d_pkg::RECIP5);
    assign w_rumble = (w_rprod[35:20] > 16'h7fff) ? 15'h7fff : w_rprod[34:20];

    assign w_vis      = !w_start && (r_y < r_horizon);
    assign w_out_free = !r_out_valid || o_result.ready;

    assign i_item.ready   = (r_state == ST_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    assign o_div_req.start = (r_state == ST_LAUNCH);
    assign o_div_req.num   = r_num;
    assign o_div_req.den   = r_den;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_item.valid) n_state = ST_SETUP;
            ST_SETUP:  n_state = w_start ? ST_FINAL : ST_PREP;
            ST_PREP:   n_state = ST_LAUNCH;
            ST_LAUNCH: n_state = ST_WAIT;
            ST_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = (r_job == JOB_W) ? ST_FINAL : ST_PREP;
                end
            end
            ST_FINAL:  if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_job         <= JOB_X;
            r_out_valid   <= 1'b0;
            r_offset      <= '0;
            r_slope       <= '0;
            r_horizon     <= 16'(pr3d_pkg::SCREEN_HEIGHT);
            r_prev_x      <= 16'(pr3d_pkg::SCREEN_WIDTH / 2);
            r_prev_y      <= 16'sh7fff;
            r_prev_hw     <= 15'h7fff;
            r_prev_rumble <= 15'h7fff;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SETUP) begin
                r_job    <= JOB_X;
                r_offset <= w_off_next;
                r_slope  <= w_slope_next;
                if (w_start) begin
                    r_horizon <= 16'(pr3d_pkg::SCREEN_HEIGHT);
                end
            end
            if (r_state == ST_WAIT && i_div_rsp.done) begin
                r_job <= r_job + 2'd1;
            end
            if (r_state == ST_FINAL && w_out_free) begin
                r_out_valid   <= 1'b1;
                r_prev_x      <= r_x;
                r_prev_y      <= r_y;
                r_prev_hw     <= r_hw;
                r_prev_rumble <= w_rumble;
                if (w_vis) begin
                    r_horizon <= r_y;
                end
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    r_num_seg <= i_item.data.segment_number;
                    r_height  <= i_item.data.segment_height;
                    r_curve   <= i_item.data.segment_curve;
                    r_depth   <= i_item.data.segment_number - i_cam.start_segment;
                end
            end
            ST_SETUP: begin
                r_rel  <= {w_off_base[31], w_off_base}
                        - {{5{i_cam.camera_lateral[15]}}, i_cam.camera_lateral, 12'b0};
                r_dh   <= {r_height[15], r_height} - {i_cam.camera_height[15], i_cam.camera_height};
                r_band <= w_band_prod[13];
                if (w_start) begin
                    r_x  <= 16'(pr3d_pkg::SCREEN_WIDTH / 2);
                    r_y  <= 16'sh7fff;
                    r_hw <= 15'h7fff;
                end
            end
            ST_PREP: begin
                r_num <= w_num_prod[NW-1:0];
                r_den <= w_den_prod[DW-1:0];
            end
            ST_WAIT: begin
                if (i_div_rsp.done) begin
                    case (r_job)
                        JOB_X:   r_x  <= w_sat16;
                        JOB_Y:   r_y  <= w_sat16;
                        default: r_hw <= w_satw;
                    endcase
                end
            end
            ST_FINAL: begin
                if (w_out_free) begin
                    r_out.visible                  <= w_vis;
                    r_out.bottom_y                 <= r_prev_y;
                    r_out.top_y                    <= r_y;
                    r_out.bottom_x                 <= r_prev_x;
                    r_out.top_x                    <= r_x;
                    r_out.bottom_half_width        <= r_prev_hw;
                    r_out.top_half_width           <= r_hw;
                    r_out.bottom_rumble_half_width <= r_prev_rumble;
                    r_out.top_rumble_half_width    <= w_rumble;
                    r_out.color_band               <= r_band;
                    r_out.clip_row                 <= r_horizon;
                end
            end
            default: ;
        endcase
    end

endmodule

### test/tb_pseudo3d_road_segment_projector_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the road segment projector: frames of segments in, quads checked.
module tb_pseudo3d_road_segment_projector_top;

    localparam logic [pr3d_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int DRAW_DISTANCE  = 300;
    localparam int LATENCY        = 66;
    localparam int RANDOM_ITEMS   = 670;
    localparam int QUIET_TAIL     = 200;
    localparam int TIMEOUT_CYCLES = 1000000;

    logic i_clk;
    logic i_rst_n;

    pr3d_stream_if #(.T(pr3d_pkg::t_item))   item_ch ();
    pr3d_stream_if #(.T(pr3d_pkg::t_result)) quad_ch ();
    pr3d_stream_if #(.T(pr3d_pkg::t_cfg))    cfg_ch ();

    pseudo3d_road_segment_projector_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (quad_ch),
        .i_cfg    (cfg_ch)
    );

    // predicted camera registers and frame state
    logic signed [15:0] cam_lateral = '0;
    logic signed [15:0] cam_height  = pr3d_pkg::CAMERA_HEIGHT_RST;
    logic [11:0]        cam_start   = '0;
    int offset_q12 = 0;
    int slope_q12  = 0;
    int horizon    = pr3d_pkg::SCREEN_HEIGHT;
    int last_x     = pr3d_pkg::SCREEN_WIDTH / 2;
    int last_y     = 32767;
    int last_hw    = 32767;

    pr3d_pkg::t_result expected_quads[$];
    int      mismatches  = 0;
    int      sent_items  = 0;
    int      cycle_count = 0;
    int      stall_left  = 0;
    bit      idling      = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic longint floor_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic int clamp16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic int clamp_width(input longint v);
        if (v > 32767) return 32767;
        if (v < 0) return 0;
        return int'(v);
    endfunction

    function automatic int add_sat32(input int a, input int b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (s < -64'sd2147483648) return 32'sh80000000;
        return int'(s);
    endfunction

    function automatic logic [14:0] rumble_width(input int hw);
        return 15'(clamp_width(longint'(hw) * 6 / 5));
    endfunction

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic void load_register(input pr3d_pkg::t_cfg w);
        case (w.reg_index)
            pr3d_pkg::REG_CAMERA_LATERAL: cam_lateral = w.wdata;
            pr3d_pkg::REG_CAMERA_HEIGHT:  cam_height  = w.wdata;
            pr3d_pkg::REG_START_SEGMENT:  cam_start   = w.wdata[11:0];
            default: ;
        endcase
    endfunction

    function automatic pr3d_pkg::t_result project_segment(input pr3d_pkg::t_item seg);
        pr3d_pkg::t_result q;
        logic [11:0]       depth;
        longint            d;
        longint            rel;
        longint            dh;
        int                x;
        int                y;
        int                hw;
        depth = seg.segment_number - cam_start;
        if (depth == '0) begin
            offset_q12 = 0;
            slope_q12  = 0;
            horizon    = pr3d_pkg::SCREEN_HEIGHT;
            x  = pr3d_pkg::SCREEN_WIDTH / 2;
            y  = 32767;
            hw = 32767;
        end else begin
            d   = longint'(depth) * pr3d_pkg::SEGMENT_SPAN;
            rel = longint'(offset_q12) - longint'(cam_lateral) * 4096;
            dh  = longint'($signed(seg.segment_height)) - longint'(cam_height);
            x  = clamp16(floor_div(longint'(pr3d_pkg::SCREEN_WIDTH) * (409600 * d + 84 * rel),
                                   819200 * d));
            y  = clamp16(floor_div(longint'(pr3d_pkg::SCREEN_HEIGHT) * (100 * d - 84 * dh),
                                   200 * d));
            hw = clamp_width(floor_div(longint'(840) * pr3d_pkg::SCREEN_WIDTH, d));
        end
        offset_q12 = add_sat32(offset_q12, slope_q12);
        slope_q12  = add_sat32(slope_q12, int'($signed(seg.segment_curve)));

        q.clip_row = 16'(horizon);
        q.visible  = (depth != '0) && (y < horizon);
        if (q.visible) begin
            horizon = y;
        end
        q.bottom_y                 = 16'(last_y);
        q.top_y                    = 16'(y);
        q.bottom_x                 = 16'(last_x);
        q.top_x                    = 16'(x);
        q.bottom_half_width        = 15'(last_hw);
        q.top_half_width           = 15'(hw);
        q.bottom_rumble_half_width = rumble_width(last_hw);
        q.top_rumble_half_width    = rumble_width(hw);
        q.color_band               = 1'((seg.segment_number / 12'd3) & 12'd1);
        last_x  = x;
        last_y  = y;
        last_hw = hw;
        return q;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // predict on input transfers, check on result transfers
    always @(posedge i_clk) begin
        pr3d_pkg::t_result want;
        pr3d_pkg::t_result got;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                load_register(cfg_ch.data);
            end
            if (item_ch.valid && item_ch.ready) begin
                expected_quads = {expected_quads, project_segment(item_ch.data)};
            end
            if (quad_ch.valid === 1'b1 && quad_ch.ready) begin
                got = quad_ch.data;
                if (expected_quads.size() == 0) begin
                    mismatches++;
                    $error("result transfer with no quad expected");
                end else begin
                    want = expected_quads.pop_front();
                    check_field("visible", want.visible, got.visible);
                    check_field("bottom_y", want.bottom_y, got.bottom_y);
                    check_field("top_y", want.top_y, got.top_y);
                    check_field("bottom_x", want.bottom_x, got.bottom_x);
                    check_field("top_x", want.top_x, got.top_x);
                    check_field("bottom_half_width", want.bottom_half_width,
                                got.bottom_half_width);
                    check_field("top_half_width", want.top_half_width, got.top_half_width);
                    check_field("bottom_rumble_half_width", want.bottom_rumble_half_width,
                                got.bottom_rumble_half_width);
                    check_field("top_rumble_half_width", want.top_rumble_half_width,
                                got.top_rumble_half_width);
                    check_field("color_band", want.color_band, got.color_band);
                    check_field("clip_row", want.clip_row, got.clip_row);
                end
            end
        end
    end

    // receiver stalls in random bursts while idling is set
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            quad_ch.ready <= 1'b0;
        end else if (idling && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 15);
            quad_ch.ready <= 1'b0;
        end else begin
            quad_ch.ready <= 1'b1;
        end
    end

    task automatic send_segment(input int num, input int hgt, input int crv);
        pr3d_pkg::t_item seg;
        seg.segment_number = 12'(num);
        seg.segment_height = 16'(hgt);
        seg.segment_curve  = 16'(crv);
        @(negedge i_clk);
        if (idling && $urandom_range(0, 3) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= seg;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        sent_items++;
    endtask

    task automatic write_reg(input logic [pr3d_pkg::REG_IDX_W-1:0] idx, input int value);
        pr3d_pkg::t_cfg w;
        w.reg_index = idx;
        w.wdata     = 16'(value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_camera(input int lateral, input int height, input int start);
        write_reg(pr3d_pkg::REG_CAMERA_LATERAL, lateral);
        write_reg(pr3d_pkg::REG_CAMERA_HEIGHT, height);
        write_reg(pr3d_pkg::REG_START_SEGMENT, start);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (expected_quads.size() != 0) @(posedge i_clk);
    endtask

    // start segment (optional) then count segments, heights as a random walk
    task automatic send_frame(input int start, input int count, input int step,
                              input bit with_start, input int curve_span, input int base_h);
        int h;
        h = base_h;
        if (with_start) begin
            send_segment(start, h, clamp16(rand_between(-curve_span, curve_span)));
        end
        for (int k = 1; k <= count; k++) begin
            h = clamp16(h + rand_between(-400, 400));
            send_segment(start + k * step, h, clamp16(rand_between(-curve_span, curve_span)));
        end
    endtask

    task automatic test_directed_frame();
        send_segment(7, 0, 0);
        send_segment(0, 0, 0);
        send_segment(1, 0, 0);
        send_segment(2, 32767, 32767);
        send_segment(3, -32768, -32768);
        send_segment(4, 0, 4096);
        send_segment(5, -20000, 0);
        send_segment(6, 400, -4096);
        send_segment(DRAW_DISTANCE, 0, 0);
        send_segment(DRAW_DISTANCE + 1, 0, 0);
        send_segment(4095, 0, 0);
        send_segment(0, 0, 0);
        send_segment(2048, 32767, 0);
        send_segment(1, -1500, 0);
        wait_idle();
    endtask

    task automatic test_camera_extremes();
        int lat[3]   = '{-32768, 32767, 0};
        int hgt[3]   = '{32767, -32768, 1500};
        int start[3] = '{4095, 2048, 0};
        for (int i = 0; i < 3; i++) begin
            set_camera(lat[i], hgt[i], start[i]);
            send_segment(start[i], 0, 0);
            send_segment(start[i] + 1, -32768, 32767);
            send_segment(start[i] + 2, 32767, -32768);
            send_segment(start[i] + 3, 0, 0);
            send_segment(start[i] + 4095, 0, 0);
            wait_idle();
        end
        // index 3 is not a register
        write_reg(REG_UNUSED, 16'hFFFF);
        send_frame(0, 4, 1, 1'b1, 2000, 0);
        wait_idle();
        write_reg(REG_UNUSED, 0);
        send_frame(0, 2, 1, 1'b1, 2000, 0);
        wait_idle();
    endtask

    // a long hard curve drives the lateral offset into saturation both ways
    task automatic test_offset_saturation();
        set_camera(0, 1500, 100);
        send_segment(100, 0, 32767);
        for (int k = 1; k <= 370; k++) begin
            send_segment(100 + k, 0, 32767);
        end
        send_segment(100, 0, -32768);
        for (int k = 1; k <= 370; k++) begin
            send_segment(100 + k, 0, -32768);
        end
        wait_idle();
    endtask

    task automatic test_random_frames();
        int target;
        int start;
        int base_h;
        int cam_h;
        int len;
        int span;
        target = sent_items + RANDOM_ITEMS;
        start  = 100;
        base_h = 0;
        while (sent_items < target) begin
            idling = (target - sent_items > QUIET_TAIL) && ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 2) == 0) begin
                wait_idle();
                cam_h = ($urandom_range(0, 4) == 0) ? int'($signed(16'($urandom)))
                                                     : rand_between(0, 6000);
                start = $urandom_range(0, 4095);
                set_camera(($urandom_range(0, 3) == 0) ? int'($signed(16'($urandom)))
                                                        : rand_between(-4000, 4000),
                           cam_h, start);
                if ($urandom_range(0, 5) == 0) begin
                    write_reg(REG_UNUSED, $urandom);
                end
                base_h = clamp16(cam_h - 1500);
            end
            span = ($urandom_range(0, 4) == 0) ? 32768 : rand_between(0, 3000);
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 8)) begin
                        send_segment($urandom, $urandom, $urandom);
                    end
                end
                1: begin
                    len = rand_between(1, 30);
                    send_frame(start, len, rand_between(-2, 4), $urandom_range(0, 1), span,
                               base_h);
                end
                default: begin
                    len = ($urandom_range(0, 19) == 0) ? DRAW_DISTANCE : rand_between(1, 40);
                    send_frame(start, len, 1, 1'b1, span, base_h);
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frame();
        test_camera_extremes();
        test_offset_saturation();
        test_random_frames();

        wait_idle();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (expected_quads.size() != 0) begin
            mismatches++;
            $error("%0d quads never arrived", expected_quads.size());
        end
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
